// ----- hdl/wsu_pkg.sv -----
// ----------------------------------------------------------------------------
// wsu_pkg
// Shared types and constants of the websocket frame unmasker
// ----------------------------------------------------------------------------
package wsu_pkg;

    localparam int unsigned LimitWidth = 17;

    localparam logic [LimitWidth-1:0] MAX_FRAME_RESET = 17'd65536;

    // sizes of the fixed part of a frame: header, extended length, mask key
    localparam logic [LimitWidth-1:0] SHORT_HDR_BYTES = 17'd6;
    localparam logic [LimitWidth-1:0] EXT_HDR_BYTES   = 17'd8;

    localparam logic       OP_DATA    = 1'b0;
    localparam logic       OP_RESTART = 1'b1;

    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_MASK   = 4'hF;

    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;

    localparam logic [1:0] KEY_LAST   = 2'd3;

    typedef enum logic [2:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_EMPTY_TEXT = 3'd1,
        KIND_CLOSE      = 3'd2,
        KIND_UNMASKED   = 3'd3,
        KIND_LONG       = 3'd4,
        KIND_OVERSIZE   = 3'd5
    } kind_t;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT_HI  = 6'b000100,
        PH_EXT_LO  = 6'b001000,
        PH_KEY     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       last;
    } result_t;

endpackage

// ----- hdl/wsu_in_if.sv -----
// ----------------------------------------------------------------------------
// wsu_in_if
// Input channel: one stream word per handshake
// ----------------------------------------------------------------------------
interface wsu_in_if;

    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source
    (
        output valid,
        output op,
        output rx_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  op,
        input  rx_byte,
        output ready
    );

endinterface

// ----- hdl/wsu_out_if.sv -----
// ----------------------------------------------------------------------------
// wsu_out_if
// Output channel: one event or payload word per handshake
// ----------------------------------------------------------------------------
interface wsu_out_if;

    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       last;

    modport source
    (
        output valid,
        output kind,
        output payload_byte,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  kind,
        input  payload_byte,
        input  last,
        output ready
    );

endinterface

// ----- hdl/wsu_parser.sv -----
// ----------------------------------------------------------------------------
// wsu_parser
// Frame header parser and payload unmasker, one word per accepted cycle
// ----------------------------------------------------------------------------
module wsu_parser
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic                               op,
    input  logic [7:0]                         rx_byte,
    input  logic [wsu_pkg::LimitWidth-1:0]     max_frame_bytes,
    output wsu_pkg::result_t                   res
);

    wsu_pkg::phase_t   phase_reg,  phase_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic [1:0]        hpos_reg,   hpos_next;
    logic [15:0]       rem_reg,    rem_next;
    logic [3:0][7:0]   key_reg,    key_next;
    logic [1:0]        kidx_reg,   kidx_next;
    logic              drop_reg,   drop_next;

    logic [wsu_pkg::LimitWidth-1:0] short_size;
    logic [wsu_pkg::LimitWidth-1:0] ext_size;
    logic [15:0]                    ext_len;
    logic [15:0]                    rem_dec;
    logic [7:0]                     plain;

    assign ext_len    = {rem_reg[15:8], rx_byte};
    assign short_size = {10'd0, rx_byte[6:0]} + wsu_pkg::SHORT_HDR_BYTES;
    assign ext_size   = {1'b0, ext_len} + wsu_pkg::EXT_HDR_BYTES;
    assign rem_dec    = rem_reg - 16'd1;
    assign plain      = rx_byte ^ key_reg[kidx_reg];

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        hpos_next   = hpos_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        drop_next   = drop_reg;
        res         = '0;

        if (take)
        begin
            if (op == wsu_pkg::OP_RESTART)
            begin
                phase_next  = wsu_pkg::PH_HDR0;
                opcode_next = '0;
                hpos_next   = '0;
                rem_next    = '0;
                key_next    = '0;
                kidx_next   = '0;
                drop_next   = 1'b0;
            end
            else if (!drop_reg)
            begin
                unique case (phase_reg)
                    wsu_pkg::PH_HDR0:
                    begin
                        opcode_next = rx_byte[3:0] & wsu_pkg::OPC_MASK;
                        phase_next  = wsu_pkg::PH_HDR1;
                    end
                    wsu_pkg::PH_HDR1:
                    begin
                        if (rx_byte[6:0] == wsu_pkg::LEN_EXT64)
                        begin
                            drop_next  = 1'b1;
                            phase_next = wsu_pkg::PH_HDR0;
                            res.valid  = 1'b1;
                            res.kind   = wsu_pkg::KIND_LONG;
                        end
                        else if (!rx_byte[7])
                        begin
                            drop_next  = 1'b1;
                            phase_next = wsu_pkg::PH_HDR0;
                            res.valid  = 1'b1;
                            res.kind   = wsu_pkg::KIND_UNMASKED;
                        end
                        else if (rx_byte[6:0] == wsu_pkg::LEN_EXT16)
                        begin
                            phase_next = wsu_pkg::PH_EXT_HI;
                        end
                        else
                        begin
                            rem_next = {9'd0, rx_byte[6:0]};
                            if (short_size > max_frame_bytes)
                            begin
                                drop_next  = 1'b1;
                                phase_next = wsu_pkg::PH_HDR0;
                                res.valid  = 1'b1;
                                res.kind   = wsu_pkg::KIND_OVERSIZE;
                            end
                            else
                            begin
                                hpos_next  = '0;
                                key_next   = '0;
                                phase_next = wsu_pkg::PH_KEY;
                            end
                        end
                    end
                    wsu_pkg::PH_EXT_HI:
                    begin
                        rem_next   = {rx_byte, 8'd0};
                        phase_next = wsu_pkg::PH_EXT_LO;
                    end
                    wsu_pkg::PH_EXT_LO:
                    begin
                        rem_next = ext_len;
                        if (ext_size > max_frame_bytes)
                        begin
                            drop_next  = 1'b1;
                            phase_next = wsu_pkg::PH_HDR0;
                            res.valid  = 1'b1;
                            res.kind   = wsu_pkg::KIND_OVERSIZE;
                        end
                        else
                        begin
                            hpos_next  = '0;
                            key_next   = '0;
                            phase_next = wsu_pkg::PH_KEY;
                        end
                    end
                    wsu_pkg::PH_KEY:
                    begin
                        key_next[hpos_reg] = rx_byte;
                        if (hpos_reg != wsu_pkg::KEY_LAST)
                        begin
                            hpos_next = hpos_reg + 2'd1;
                        end
                        else
                        begin
                            hpos_next = '0;
                            kidx_next = '0;
                            if (rem_reg != 16'd0)
                            begin
                                phase_next = wsu_pkg::PH_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = wsu_pkg::PH_HDR0;
                                if (opcode_reg == wsu_pkg::OPC_TEXT)
                                begin
                                    res.valid = 1'b1;
                                    res.kind  = wsu_pkg::KIND_EMPTY_TEXT;
                                end
                                else if (opcode_reg == wsu_pkg::OPC_CLOSE)
                                begin
                                    res.valid = 1'b1;
                                    res.kind  = wsu_pkg::KIND_CLOSE;
                                end
                            end
                        end
                    end
                    wsu_pkg::PH_PAYLOAD:
                    begin
                        kidx_next = kidx_reg + 2'd1;
                        rem_next  = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            phase_next = wsu_pkg::PH_HDR0;
                        end
                        if (opcode_reg == wsu_pkg::OPC_TEXT)
                        begin
                            res.valid        = 1'b1;
                            res.kind         = wsu_pkg::KIND_PAYLOAD;
                            res.payload_byte = plain;
                            res.last         = (rem_dec == 16'd0);
                        end
                        else if (opcode_reg == wsu_pkg::OPC_CLOSE && rem_dec == 16'd0)
                        begin
                            res.valid = 1'b1;
                            res.kind  = wsu_pkg::KIND_CLOSE;
                        end
                    end
                    default:
                    begin
                        phase_next = wsu_pkg::PH_HDR0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsu_pkg::PH_HDR0;
            opcode_reg <= '0;
            hpos_reg   <= '0;
            rem_reg    <= '0;
            key_reg    <= '0;
            kidx_reg   <= '0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            hpos_reg   <= hpos_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            drop_reg   <= drop_next;
        end
    end

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && op == wsu_pkg::OP_RESTART |=> phase_reg == wsu_pkg::PH_HDR0 && !drop_reg)
        else $error("restart did not return to header state");

    a_result_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> take && op == wsu_pkg::OP_DATA && !drop_reg)
        else $error("result without an accepted data word");

    a_payload_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsu_pkg::PH_PAYLOAD |-> rem_reg != 16'd0)
        else $error("payload state with zero remaining length");

    a_error_enters_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == wsu_pkg::KIND_UNMASKED || res.kind == wsu_pkg::KIND_LONG
                      || res.kind == wsu_pkg::KIND_OVERSIZE) |=> drop_reg)
        else $error("error result without drop mode");
`endif

endmodule

// ----- hdl/websocket_frame_unmasker_top.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_top
// Client-to-server websocket frame parser and payload unmasker
// ----------------------------------------------------------------------------
// One stream word is accepted per clock unless the output stalls: each word
// is handled in the cycle it is taken, and its result (if any) lands in a
// single output register, so frame_in stays ready while that register is
// empty or being drained. That result reaches event_out in the cycle after
// the word is taken. Text payload bytes come out unmasked with last on the
// final byte, close frames give a close event, and framing errors give an
// error word and drop all input until a restart word. max_frame_bytes may be
// written whenever the block is idle; no clearing pass is needed after reset.
module websocket_frame_unmasker_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    wsu_in_if.sink                         frame_in,
    wsu_out_if.source                      event_out,
    input  logic                           cfg_we,
    input  logic [wsu_pkg::LimitWidth-1:0] cfg_wdata
);

    logic [wsu_pkg::LimitWidth-1:0] max_reg;
    logic                           out_valid_reg;
    wsu_pkg::kind_t                 out_kind_reg;
    logic [7:0]                     out_byte_reg;
    logic                           out_last_reg;
    logic                           take;
    wsu_pkg::result_t               res;

    assign frame_in.ready = !out_valid_reg || event_out.ready;
    assign take           = frame_in.valid && frame_in.ready;

    wsu_parser u_parser
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .op              (frame_in.op),
        .rx_byte         (frame_in.rx_byte),
        .max_frame_bytes (max_reg),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= wsu_pkg::MAX_FRAME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            if (frame_in.ready)
            begin
                out_valid_reg <= res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.ready && res.valid)
        begin
            out_kind_reg <= res.kind;
            out_byte_reg <= res.payload_byte;
            out_last_reg <= res.last;
        end
    end

    assign event_out.valid        = out_valid_reg;
    assign event_out.kind         = out_kind_reg;
    assign event_out.payload_byte = out_byte_reg;
    assign event_out.last         = out_last_reg;

`ifndef SYNTHESIS
    a_event_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        event_out.valid && event_out.kind != wsu_pkg::KIND_PAYLOAD
        |-> event_out.payload_byte == 8'd0 && !event_out.last)
        else $error("non-payload word carries data");

    a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
        take && res.valid |=> out_valid_reg)
        else $error("result lost at the output register");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !event_out.ready |-> !take)
        else $error("word taken while output is stalled");
`endif

endmodule
